FILE: design/jlex_pkg.sv
// types, codes and character constants shared by the json lexer
`timescale 1ns / 1ps
package jlex_pkg;

  // scanner modes
  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_SLASH = 4'd1,
    M_LINE  = 4'd2,
    M_BLOCK = 4'd3,
    M_STAR  = 4'd4,
    M_NUM   = 4'd5,
    M_STR0  = 4'd6,
    M_STR   = 4'd7,
    M_ESC0  = 4'd8,
    M_ESC   = 4'd9,
    M_IDENT = 4'd10,
    M_ERR   = 4'd11
  } mode_e;

  // result kinds
  typedef enum logic [1:0] {
    K_CHAR = 2'd0,
    K_END  = 2'd1,
    K_ERR  = 2'd2,
    K_EOT  = 2'd3
  } kind_e;

  // token types
  localparam logic [1:0] TT_PUNCT = 2'd0;
  localparam logic [1:0] TT_NUM   = 2'd1;
  localparam logic [1:0] TT_TEXT  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_COMMENT = 2'd1;
  localparam logic [1:0] ERR_STRING  = 2'd2;
  localparam logic [1:0] ERR_BYTE    = 2'd3;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_N   = 8'h6E;
  localparam logic [7:0] CH_LO_R   = 8'h72;
  localparam logic [7:0] CH_LO_T   = 8'h74;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // one result item
  typedef struct packed {
    kind_e      kind;
    logic [1:0] ttype;
    logic [7:0] data;
    logic       first;
    logic [1:0] err;
  } res_t;

  // output queue
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

endpackage

FILE: design/json_lexer_with_comments_core.sv
// streaming json lexer with comment skipping, one text byte per transfer
`timescale 1ns / 1ps
// Takes text one byte per transfer (tuser high marks end of text, tdata then
// ignored) and sends tokens one character per transfer, with token ends,
// errors and an end-of-text marker as extra transfers. Whitespace, line and
// block comments are skipped, strings decode \t \r \n, and an error is sticky
// until end of text. A byte is taken into an input register, then scanned
// combinationally and its zero, one or two results go into a four-entry output
// queue. The block accepts one byte per cycle as long as the queue has room
// for two results; since one byte gives at most two results and the queue
// drains one per cycle, a sink that is always ready sees a stall only after
// bytes that give two results (a token closed by a byte that gives a result of
// its own, or end of text after an open token, block comment or string).
module json_lexer_with_comments_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tuser_i,   // [0] end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_byte, [9:8] error_code, rest zero
  output logic [4:0]  m_axis_tuser_o    // [1:0] out_kind, [3:2] token_type, [4] first_char
);
  import jlex_pkg::*;

  // input register
  logic       stg_vld_q;
  logic [7:0] stg_byte_q;
  logic       stg_eot_q;

  // scanner state
  mode_e mode_q, mode_d;
  logic  dot_q, dot_d;

  // output queue
  res_t             q_mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  // scan results of the registered byte
  res_t       r0, r1;
  logic [1:0] push_n;
  logic       proc, pop;

  // result of treating the byte as if the scanner were idle
  res_t  idl_res;
  logic  idl_has;
  mode_e idl_mode;
  logic  idl_dot;

  logic [7:0] b;
  logic       is_digit, is_id_start;
  logic [7:0] esc_byte;
  logic       tok_close;

  assign b           = stg_byte_q;
  assign is_digit    = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_id_start = (b == CH_UNDER) || ((b >= CH_LO_A) && (b <= CH_LO_Z)) ||
                       ((b >= CH_UP_A) && (b <= CH_UP_Z)) || b[7];

  // open number or identifier ended by a byte that cannot extend it
  assign tok_close = ((mode_q == M_NUM) && !is_digit && !((b == CH_DOT) && !dot_q)) ||
                     ((mode_q == M_IDENT) && !is_id_start && !is_digit);

  // queue has room for the worst case of two results
  assign proc            = stg_vld_q && (cnt_q <= QCntW'(QDepth - 2));
  assign s_axis_tready_o = !stg_vld_q || proc;
  assign pop             = m_axis_tvalid_o && m_axis_tready_i;

  // escape decode
  always_comb begin
    case (b)
      CH_LO_T: esc_byte = CH_TAB;
      CH_LO_R: esc_byte = CH_CR;
      CH_LO_N: esc_byte = CH_LF;
      default: esc_byte = b;
    endcase
  end

  // idle handling of a byte, also used after a token is closed
  always_comb begin
    idl_res  = '{kind: K_CHAR, ttype: TT_PUNCT, data: b, first: 1'b1, err: ERR_NONE};
    idl_has  = 1'b0;
    idl_mode = M_IDLE;
    idl_dot  = 1'b0;
    if (b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF}) begin
      idl_has = 1'b0;
    end else if (b == CH_SLASH) begin
      idl_mode = M_SLASH;
    end else if ((b inside {CH_PLUS, CH_MINUS, CH_DOT}) || is_digit) begin
      idl_has       = 1'b1;
      idl_res.ttype = TT_NUM;
      idl_mode      = M_NUM;
      idl_dot       = (b == CH_DOT);
    end else if (b == CH_QUOTE) begin
      idl_mode = M_STR0;
    end else if (is_id_start) begin
      idl_has       = 1'b1;
      idl_res.ttype = TT_TEXT;
      idl_mode      = M_IDENT;
    end else if (b inside {CH_COMMA, CH_LBRACE, CH_RBRACE, CH_COLON, CH_LBRACK,
                           CH_RBRACK}) begin
      idl_has = 1'b1;
    end else begin
      idl_has  = 1'b1;
      idl_res  = '{kind: K_ERR, ttype: TT_PUNCT, data: 8'd0, first: 1'b0, err: ERR_BYTE};
      idl_mode = M_ERR;
    end
  end

  // next scanner state
  always_comb begin
    mode_d = mode_q;
    dot_d  = dot_q;
    if (stg_eot_q) begin
      mode_d = M_IDLE;
      dot_d  = 1'b0;
    end else if (tok_close) begin
      // token closed by this byte: the byte is then taken from idle
      mode_d = idl_mode;
      dot_d  = idl_dot;
    end else begin
      case (mode_q)
        M_SLASH: begin
          if (b == CH_SLASH) begin
            mode_d = M_LINE;
          end else if (b == CH_STAR) begin
            mode_d = M_BLOCK;
          end else begin
            mode_d = idl_mode;
            dot_d  = idl_dot;
          end
        end
        M_LINE: begin
          if (b inside {CH_CR, CH_LF}) mode_d = M_IDLE;
        end
        M_BLOCK: begin
          if (b == CH_STAR) mode_d = M_STAR;
        end
        M_STAR: begin
          if (b == CH_SLASH) begin
            mode_d = M_IDLE;
          end else if (b != CH_STAR) begin
            mode_d = M_BLOCK;
          end
        end
        M_NUM: begin
          // a digit or the first dot keeps the number open
          if (b == CH_DOT) dot_d = 1'b1;
        end
        M_STR0, M_STR: begin
          if (b == CH_QUOTE) begin
            mode_d = M_IDLE;
          end else if (b == CH_BSLASH) begin
            mode_d = (mode_q == M_STR0) ? M_ESC0 : M_ESC;
          end else begin
            mode_d = M_STR;
          end
        end
        M_ESC0, M_ESC: begin
          mode_d = M_STR;
        end
        M_IDENT, M_ERR: begin
          mode_d = mode_q;
        end
        default: begin
          mode_d = idl_mode;
          dot_d  = idl_dot;
        end
      endcase
    end
  end

  // scan outputs
  always_comb begin
    res_t tok_end;
    res_t tok_chr;
    tok_end = '{kind: K_END, ttype: TT_NUM, data: 8'd0, first: 1'b0, err: ERR_NONE};
    tok_chr = '{kind: K_CHAR, ttype: TT_TEXT, data: b, first: 1'b0, err: ERR_NONE};
    r0      = '{kind: K_EOT, ttype: TT_PUNCT, data: 8'd0, first: 1'b0, err: ERR_NONE};
    r1      = r0;
    push_n  = 2'd0;

    if (stg_eot_q) begin
      // optional closing result, then the end-of-text marker
      push_n = 2'd2;
      case (mode_q)
        M_NUM:   r0 = tok_end;
        M_IDENT: r0 = '{kind: K_END, ttype: TT_TEXT, data: 8'd0, first: 1'b0,
                        err: ERR_NONE};
        M_BLOCK, M_STAR:
          r0 = '{kind: K_ERR, ttype: TT_PUNCT, data: 8'd0, first: 1'b0,
                 err: ERR_COMMENT};
        M_STR0, M_STR, M_ESC0, M_ESC:
          r0 = '{kind: K_ERR, ttype: TT_PUNCT, data: 8'd0, first: 1'b0,
                 err: ERR_STRING};
        default: push_n = 2'd1;
      endcase
    end else if (tok_close) begin
      // token end first, then the byte from idle
      if (mode_q == M_IDENT) tok_end.ttype = TT_TEXT;
      r0     = tok_end;
      r1     = idl_res;
      push_n = idl_has ? 2'd2 : 2'd1;
    end else begin
      case (mode_q)
        M_SLASH: begin
          if (!(b inside {CH_SLASH, CH_STAR})) begin
            r0     = idl_res;
            push_n = {1'b0, idl_has};
          end
        end
        M_LINE, M_BLOCK, M_STAR, M_ERR: begin
          push_n = 2'd0;
        end
        M_NUM: begin
          tok_chr.ttype = TT_NUM;
          r0            = tok_chr;
          push_n        = 2'd1;
        end
        M_STR0, M_STR: begin
          if (b == CH_QUOTE) begin
            r0     = '{kind: K_END, ttype: TT_TEXT, data: 8'd0, first: 1'b0,
                       err: ERR_NONE};
            push_n = 2'd1;
          end else if (b != CH_BSLASH) begin
            tok_chr.first = (mode_q == M_STR0);
            r0            = tok_chr;
            push_n        = 2'd1;
          end
        end
        M_ESC0, M_ESC: begin
          tok_chr.first = (mode_q == M_ESC0);
          tok_chr.data  = esc_byte;
          r0            = tok_chr;
          push_n        = 2'd1;
        end
        M_IDENT: begin
          r0     = tok_chr;
          push_n = 2'd1;
        end
        default: begin
          r0     = idl_res;
          push_n = {1'b0, idl_has};
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (s_axis_tvalid_i && s_axis_tready_o) begin
      stg_vld_q <= 1'b1;
    end else if (proc) begin
      stg_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      stg_byte_q <= s_axis_tdata_i;
      stg_eot_q  <= s_axis_tuser_i;
    end
  end

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      dot_q  <= 1'b0;
    end else if (proc) begin
      mode_q <= mode_d;
      dot_q  <= dot_d;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (proc) wr_ptr_q <= wr_ptr_q + QPtrW'(push_n);
      if (pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      cnt_q <= cnt_q + (proc ? QCntW'(push_n) : QCntW'(0)) - QCntW'(pop);
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (proc && (push_n != 2'd0)) q_mem_q[wr_ptr_q] <= r0;
    if (proc && (push_n == 2'd2)) q_mem_q[wr_ptr_q + QPtrW'(1)] <= r1;
  end

  // result port
  res_t head;
  assign head            = q_mem_q[rd_ptr_q];
  assign m_axis_tvalid_o = (cnt_q != '0);
  assign m_axis_tdata_o  = {6'd0, head.err, head.data};
  assign m_axis_tuser_o  = {head.first, head.ttype, head.kind};

`ifndef ASSERT_OFF
  // queue never overfills
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("output queue overfilled");

  // end of text always leaves at least the marker
  a_eot_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && stg_eot_q) |-> (push_n != 2'd0))
    else $error("end of text produced no result");

  // sticky error swallows ordinary bytes
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && !stg_eot_q && (mode_q == M_ERR)) |-> (push_n == 2'd0 && mode_d == M_ERR))
    else $error("byte emitted while in error");

  // scanner is idle after end of text
  a_eot_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && stg_eot_q) |=> (mode_q == M_IDLE && !dot_q))
    else $error("scanner not reset by end of text");

  // first-character flag only rides on token characters
  a_first_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && head.first) |-> (head.kind == K_CHAR))
    else $error("first flag on non-character result");
`endif

endmodule

FILE: dv/tb.sv
// self-checking testbench for the streaming json lexer core
`timescale 1ns / 1ps
module tb;
  import jlex_pkg::*;

  localparam int         DirectedRows = 25;
  localparam int         RandomItems  = 1950;
  localparam int         StallLimit   = 5000;
  localparam int         HoldCycles   = 400;
  localparam int         TailCycles   = 16;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_ASCII_TOP = 8'd127;

  localparam res_t NO_RES  = '0;
  localparam res_t EOT_RES = '{K_EOT, TT_PUNCT, 8'h00, 1'b0, ERR_NONE};

  // one directed row: typed-in results are used only when use_table is set
  typedef struct {
    logic [7:0] text_byte;
    logic       eot;
    bit         use_table;
    int         n;
    res_t       r0;
    res_t       r1;
  } stim_row_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tuser  = 1'b0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [15:0] m_axis_tdata_o;
  logic [4:0]  m_axis_tuser_o;

  json_lexer_with_comments_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // directed text: numbers, escapes, empty string, identifier, comment and error cases
  stim_row_t directed_rows [DirectedRows] = '{
    '{8'hFF,     1'b1, 1'b1, 1, EOT_RES, NO_RES},
    '{CH_LBRACE, 1'b0, 1'b1, 1, '{K_CHAR, TT_PUNCT, CH_LBRACE, 1'b1, ERR_NONE}, NO_RES},
    '{CH_MINUS,  1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_NINE,   1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_DOT,    1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_DOT,    1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_SPACE,  1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_QUOTE,  1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_BSLASH, 1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_LO_N,   1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_BSLASH, 1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_LO_T,   1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_QUOTE,  1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_QUOTE,  1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_QUOTE,  1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{8'hFF,     1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_ZERO,   1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_SLASH,  1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{CH_STAR,   1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{8'h00,     1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{8'h00,     1'b1, 1'b1, 2, '{K_ERR, TT_PUNCT, 8'h00, 1'b0, ERR_COMMENT}, EOT_RES},
    '{CH_QUOTE,  1'b0, 1'b0, 0, NO_RES, NO_RES},
    '{8'hA5,     1'b1, 1'b1, 2, '{K_ERR, TT_PUNCT, 8'h00, 1'b0, ERR_STRING}, EOT_RES},
    '{CH_HASH,   1'b0, 1'b1, 1, '{K_ERR, TT_PUNCT, 8'h00, 1'b0, ERR_BYTE}, NO_RES},
    '{8'h5A,     1'b1, 1'b1, 1, EOT_RES, NO_RES}
  };

  // lexer state as seen by the predictor
  mode_e lex_mode = M_IDLE;
  logic  lex_dot  = 1'b0;
  res_t  step_out [2];
  int    step_n;
  res_t  expected_tokens [$];

  // what the sender offers along with the byte
  bit   drive_table = 1'b0;
  int   drive_n     = 0;
  res_t drive_res [2];

  int src_idle_pct = 6;
  int snk_idle_pct = 63;
  int phase        = 0;
  int fails        = 0;
  int bytes_sent   = 0;
  int random_sent  = 0;
  int texts_sent   = 0;
  int kind_seen [4];

  logic [7:0] text_q [$];

  // appends one byte to the text being built
  function automatic void add_byte(logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endfunction

  // appends one result to the expected stream
  function automatic void expect_res(res_t r);
    expected_tokens.insert(expected_tokens.size(), r);
  endfunction

  function automatic void emit_res(kind_e k, logic [1:0] tt, logic [7:0] d, logic f,
                                   logic [1:0] e);
    step_out[step_n] = '{k, tt, d, f, e};
    step_n++;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  function automatic bit is_name_start(logic [7:0] b);
    return b == CH_UNDER || (b >= CH_LO_A && b <= CH_LO_Z) ||
           (b >= CH_UP_A && b <= CH_UP_Z) || b > CH_ASCII_TOP;
  endfunction

  // a byte seen with no token open
  function automatic void scan_fresh(logic [7:0] b);
    lex_mode = M_IDLE;
    lex_dot  = 1'b0;
    if (b == CH_SLASH) begin
      lex_mode = M_SLASH;
    end else if (b == CH_PLUS || b == CH_MINUS || b == CH_DOT || is_digit(b)) begin
      emit_res(K_CHAR, TT_NUM, b, 1'b1, ERR_NONE);
      lex_mode = M_NUM;
      lex_dot  = (b == CH_DOT);
    end else if (b == CH_QUOTE) begin
      lex_mode = M_STR0;
    end else if (is_name_start(b)) begin
      emit_res(K_CHAR, TT_TEXT, b, 1'b1, ERR_NONE);
      lex_mode = M_IDENT;
    end else if (b == CH_COMMA || b == CH_LBRACE || b == CH_RBRACE || b == CH_COLON ||
                 b == CH_LBRACK || b == CH_RBRACK) begin
      emit_res(K_CHAR, TT_PUNCT, b, 1'b1, ERR_NONE);
    end else if (!(b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)) begin
      emit_res(K_ERR, TT_PUNCT, 8'h00, 1'b0, ERR_BYTE);
      lex_mode = M_ERR;
    end
  endfunction

  // advances the lexer state by one transfer, results land in step_out
  function automatic void scan_byte(logic [7:0] b, logic eot);
    logic [7:0] dec;
    step_n = 0;
    if (eot) begin
      case (lex_mode)
        M_NUM:   emit_res(K_END, TT_NUM, 8'h00, 1'b0, ERR_NONE);
        M_IDENT: emit_res(K_END, TT_TEXT, 8'h00, 1'b0, ERR_NONE);
        M_BLOCK, M_STAR: emit_res(K_ERR, TT_PUNCT, 8'h00, 1'b0, ERR_COMMENT);
        M_STR0, M_STR, M_ESC0, M_ESC: emit_res(K_ERR, TT_PUNCT, 8'h00, 1'b0, ERR_STRING);
        default: ;
      endcase
      emit_res(K_EOT, TT_PUNCT, 8'h00, 1'b0, ERR_NONE);
      lex_mode = M_IDLE;
      lex_dot  = 1'b0;
    end else begin
      case (lex_mode)
        M_SLASH: begin
          if (b == CH_SLASH) lex_mode = M_LINE;
          else if (b == CH_STAR) lex_mode = M_BLOCK;
          else scan_fresh(b);
        end
        M_LINE: begin
          if (b == CH_CR || b == CH_LF) lex_mode = M_IDLE;
        end
        M_BLOCK: begin
          if (b == CH_STAR) lex_mode = M_STAR;
        end
        M_STAR: begin
          if (b == CH_SLASH) lex_mode = M_IDLE;
          else if (b != CH_STAR) lex_mode = M_BLOCK;
        end
        M_NUM: begin
          if (is_digit(b)) begin
            emit_res(K_CHAR, TT_NUM, b, 1'b0, ERR_NONE);
          end else if (b == CH_DOT && !lex_dot) begin
            emit_res(K_CHAR, TT_NUM, b, 1'b0, ERR_NONE);
            lex_dot = 1'b1;
          end else begin
            emit_res(K_END, TT_NUM, 8'h00, 1'b0, ERR_NONE);
            scan_fresh(b);
          end
        end
        M_STR0, M_STR: begin
          if (b == CH_QUOTE) begin
            emit_res(K_END, TT_TEXT, 8'h00, 1'b0, ERR_NONE);
            lex_mode = M_IDLE;
          end else if (b == CH_BSLASH) begin
            lex_mode = (lex_mode == M_STR0) ? M_ESC0 : M_ESC;
          end else begin
            emit_res(K_CHAR, TT_TEXT, b, lex_mode == M_STR0, ERR_NONE);
            lex_mode = M_STR;
          end
        end
        M_ESC0, M_ESC: begin
          dec = b;
          if (b == CH_LO_T) dec = CH_TAB;
          else if (b == CH_LO_R) dec = CH_CR;
          else if (b == CH_LO_N) dec = CH_LF;
          emit_res(K_CHAR, TT_TEXT, dec, lex_mode == M_ESC0, ERR_NONE);
          lex_mode = M_STR;
        end
        M_IDENT: begin
          if (is_name_start(b) || is_digit(b)) begin
            emit_res(K_CHAR, TT_TEXT, b, 1'b0, ERR_NONE);
          end else begin
            emit_res(K_END, TT_TEXT, 8'h00, 1'b0, ERR_NONE);
            scan_fresh(b);
          end
        end
        M_ERR: ;
        default: scan_fresh(b);
      endcase
    end
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
      fails++;
    end
  endfunction

  // input transfers feed the predictor, output transfers are checked, in one
  // process so a same-edge push and pop cannot race
  always @(posedge clk_i) begin : monitor
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (s_tvalid && s_axis_tready_o) begin
        scan_byte(s_tdata, s_tuser);
        if (drive_table) begin
          for (int i = 0; i < drive_n; i++) expect_res(drive_res[i]);
        end else begin
          for (int i = 0; i < step_n; i++) expect_res(step_out[i]);
        end
      end
      if (m_axis_tvalid_o && m_tready) begin
        got = '{kind_e'(m_axis_tuser_o[1:0]), m_axis_tuser_o[3:2], m_axis_tdata_o[7:0],
                m_axis_tuser_o[4], m_axis_tdata_o[9:8]};
        kind_seen[got.kind]++;
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0h", $time, got);
          fails++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("out_kind", want.kind, got.kind);
          check_field("token_type", want.ttype, got.ttype);
          check_field("out_byte", want.data, got.data);
          check_field("first_char", want.first, got.first);
          check_field("error_code", want.err, got.err);
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off once the last phase starts
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (phase == 2 && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // watchdog on cycles with no transfer on either side
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("json_lexer_with_comments_core: mismatch");
        $finish;
      end
    end
  end

  // offers one byte from a falling edge and returns on the falling edge after it is taken
  task automatic send_byte(logic [7:0] b, logic eot, bit use_table, int n, res_t r0, res_t r1);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid    <= 1'b1;
    s_tdata     <= b;
    s_tuser     <= eot;
    drive_table <= use_table;
    drive_n     <= n;
    drive_res[0] <= r0;
    drive_res[1] <= r1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] any_name_char(bit allow_digit);
    case ($urandom_range(0, allow_digit ? 4 : 3))
      0: return CH_UNDER;
      1: return CH_LO_A + 8'($urandom_range(0, 25));
      2: return CH_UP_A + 8'($urandom_range(0, 25));
      3: return 8'($urandom_range(128, 255));
      default: return CH_ZERO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic void add_number();
    case ($urandom_range(0, 5))
      0: add_byte(CH_PLUS);
      1: add_byte(CH_MINUS);
      2: add_byte(CH_DOT);
      default: add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endcase
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 7) == 0) add_byte(CH_DOT);
      else add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  // string with random content and escapes; sometimes left open
  function automatic void add_string();
    logic [7:0] c;
    add_byte(CH_QUOTE);
    repeat ($urandom_range(0, 6)) begin
      if ($urandom_range(0, 4) == 0) begin
        add_byte(CH_BSLASH);
        case ($urandom_range(0, 5))
          0: add_byte(CH_LO_T);
          1: add_byte(CH_LO_R);
          2: add_byte(CH_LO_N);
          3: add_byte(CH_QUOTE);
          4: add_byte(CH_BSLASH);
          default: add_byte(8'($urandom_range(0, 255)));
        endcase
      end else begin
        c = 8'($urandom_range(0, 255));
        if (c == CH_QUOTE || c == CH_BSLASH) c = CH_SPACE;
        add_byte(c);
      end
    end
    if ($urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
  endfunction

  function automatic void add_comment(bit block);
    logic [7:0] c;
    add_byte(CH_SLASH);
    add_byte(block ? CH_STAR : CH_SLASH);
    repeat ($urandom_range(0, 8)) begin
      c = ($urandom_range(0, 3) == 0) ? CH_STAR : 8'($urandom_range(0, 255));
      if (!block && (c == CH_CR || c == CH_LF)) c = CH_SPACE;
      if (block && c == CH_SLASH) c = CH_STAR;
      add_byte(c);
    end
    if (block) begin
      add_byte(CH_STAR);
      add_byte(CH_SLASH);
    end else begin
      add_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    end
  endfunction

  // a random text made of mostly well-formed tokens, closed by end of text
  task automatic send_text();
    int pick;
    text_q.delete();
    repeat ($urandom_range(1, 14)) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        case ($urandom_range(0, 3))
          0: add_byte(CH_SPACE);
          1: add_byte(CH_TAB);
          2: add_byte(CH_CR);
          default: add_byte(CH_LF);
        endcase
      end else if (pick < 27) begin
        case ($urandom_range(0, 5))
          0: add_byte(CH_COMMA);
          1: add_byte(CH_LBRACE);
          2: add_byte(CH_RBRACE);
          3: add_byte(CH_COLON);
          4: add_byte(CH_LBRACK);
          default: add_byte(CH_RBRACK);
        endcase
      end else if (pick < 42) begin
        add_number();
      end else if (pick < 60) begin
        add_string();
      end else if (pick < 74) begin
        add_byte(any_name_char(1'b0));
        repeat ($urandom_range(0, 5)) add_byte(any_name_char(1'b1));
      end else if (pick < 80) begin
        add_comment(1'b0);
      end else if (pick < 86) begin
        add_comment(1'b1);
      end else if (pick < 90) begin
        // lone slash, the next byte is lexed normally
        add_byte(CH_SLASH);
      end else if (pick < 94) begin
        add_byte(8'($urandom_range(0, 255)));
      end else begin
        // open comment or string that runs into the end of text
        add_byte($urandom_range(0, 1) ? CH_QUOTE : CH_SLASH);
        if (text_q[$] == CH_SLASH) add_byte(CH_STAR);
      end
      if ($urandom_range(0, 9) < 6) add_byte(CH_SPACE);
    end
    foreach (text_q[i]) send_byte(text_q[i], 1'b0, 1'b0, 0, NO_RES, NO_RES);
    send_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, 0, NO_RES, NO_RES);
    random_sent += text_q.size() + 1;
    texts_sent++;
  endtask

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].text_byte, directed_rows[i].eot, directed_rows[i].use_table,
                directed_rows[i].n, directed_rows[i].r0, directed_rows[i].r1);
    end

    // three idle profiles: slow sink, slow source, then full rate with one long hold
    for (int p = 0; p < 3; p++) begin
      phase        = p;
      src_idle_pct = (p == 0) ? 6 : (p == 1) ? 63 : 0;
      snk_idle_pct = (p == 0) ? 63 : (p == 1) ? 6 : 0;
      while (random_sent < RandomItems * (p + 1) / 3) send_text();
    end
    s_tvalid <= 1'b0;

    while (expected_tokens.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (expected_tokens.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_tokens.size());
      fails++;
    end
    $display("sent %0d bytes (%0d random texts); results: %0d chars, %0d ends, %0d errors, %0d eot",
             bytes_sent, texts_sent, kind_seen[K_CHAR], kind_seen[K_END],
             kind_seen[K_ERR], kind_seen[K_EOT]);
    $display("covered slow sink, slow source, full rate and a %0d-cycle sink hold-off",
             HoldCycles);
    if (fails == 0) begin
      $display("json_lexer_with_comments_core: match");
    end else begin
      $display("json_lexer_with_comments_core: mismatch");
    end
    $finish;
  end

endmodule
